/* rtl/plk_pkg.sv */
// Shared types, codes and sizes for the page lock table.
// Used by page_lock_table; depends on nothing else.
package plk_pkg;

  // The slot index is taken from the low page bits, so the slot count is a power of two.
  localparam int SLOT_COUNT = 4096;
  localparam int SLOT_AW    = $clog2(SLOT_COUNT);
  localparam int TXN_COUNT  = 16;
  localparam int TXN_W      = 4;
  localparam int RD_BITS    = 16;
  localparam int WR_BITS    = 5;
  localparam int SLOW_BITS  = 8;
  localparam int SLOT_W     = RD_BITS + WR_BITS + SLOW_BITS;

  localparam logic [SLOW_BITS-1:0] SLOW_MAX = '1;

  localparam logic [2:0] KIND_READ       = 3'd0;
  localparam logic [2:0] KIND_WRITE      = 3'd1;
  localparam logic [2:0] KIND_RELEASE    = 3'd2;
  localparam logic [2:0] KIND_SLOW_ENTER = 3'd3;
  localparam logic [2:0] KIND_SLOW_LEAVE = 3'd4;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_HELD = 2'd1;
  localparam logic [1:0] ST_BUSY = 2'd2;

  typedef struct packed {
    logic [2:0]       kind;
    logic [TXN_W-1:0] txn_id;
    logic [31:0]      page_number;
  } plk_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [TXN_W-1:0]     blocker_id;
    logic                 writer_present;
    logic [TXN_W-1:0]     writer_id;
    logic [RD_BITS-1:0]   reader_mask;
    logic [SLOW_BITS-1:0] slow_readers;
    logic                 count_error;
  } plk_out_t;

  typedef struct packed {
    logic [SLOW_BITS-1:0] slow;
    logic [WR_BITS-1:0]   writer;
    logic [RD_BITS-1:0]   readers;
  } plk_slot_t;

  typedef enum logic [1:0] {
    PLK_CLEAR,
    PLK_IDLE,
    PLK_EXEC
  } plk_state_t;

  // Index of the lowest set bit; zero when the mask is empty.
  function automatic logic [TXN_W-1:0] plk_lowest(input logic [RD_BITS-1:0] m);
    logic [TXN_W-1:0] res;
    res = '0;
    for (int i = RD_BITS - 1; i >= 0; i--) begin
      if (m[i]) begin
        res = TXN_W'(i);
      end
    end
    return res;
  endfunction

endpackage

/* rtl/page_lock_table.sv */
// Page lock table: slot store in plk_ram and the lock update logic.
// Depends on plk_pkg and plk_ram.
//
// After reset the block sweeps all SLOT_COUNT (4096) slots to zero, one slot per
// cycle, with busy high. Afterwards each request beat is taken when start is high
// and busy is low. The block first reads the slot from the RAM, then updates it and
// writes it back with busy high. The result is on out_data with out_valid high for
// one cycle, the cycle after the write back, and cannot be held off; busy is
// already low in that cycle, so a new request may start while the result is shown.
// A new request is not taken until the previous one has been written back.
module page_lock_table (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  plk_pkg::plk_in_t in_data,
  output logic             out_valid,
  output plk_pkg::plk_out_t out_data
);
  import plk_pkg::*;

  plk_state_t state_r, state_nxt;
  logic [SLOT_AW-1:0] clr_idx_r, clr_idx_nxt;
  plk_in_t   req_r;
  logic      out_valid_r;
  plk_out_t  out_data_r, res;
  plk_slot_t rd_slot, new_slot;

  logic               ram_we;
  logic [SLOT_AW-1:0] ram_waddr;
  logic [SLOT_W-1:0]  ram_wdata;
  logic [SLOT_W-1:0]  ram_rdata;

  logic accept;
  assign accept = start && (state_r == PLK_IDLE);
  assign busy   = (state_r != PLK_IDLE);

  plk_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(SLOT_COUNT)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(in_data.page_number[SLOT_AW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PLK_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= (state_r == PLK_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    if (state_r == PLK_EXEC) begin
      out_data_r <= res;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    ram_we      = 1'b0;
    ram_waddr   = req_r.page_number[SLOT_AW-1:0];
    ram_wdata   = new_slot;
    case (state_r)
      PLK_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        ram_wdata   = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == SLOT_AW'(SLOT_COUNT - 1)) begin
          state_nxt = PLK_IDLE;
        end
      end
      PLK_IDLE: begin
        if (start) begin
          state_nxt = PLK_EXEC;
        end
      end
      PLK_EXEC: begin
        ram_we    = 1'b1;
        state_nxt = PLK_IDLE;
      end
      default: begin
        state_nxt = PLK_CLEAR;
      end
    endcase
  end

  // Lock update on the slot read for the held request.
  logic               txn_ok;
  logic [RD_BITS-1:0] own_bit, others;
  logic [WR_BITS-1:0] own_wr;
  logic               is_writer;

  assign rd_slot   = ram_rdata;
  assign txn_ok    = ({1'b0, req_r.txn_id} < (TXN_W + 1)'(TXN_COUNT));
  assign own_bit   = txn_ok ? (RD_BITS'(1) << req_r.txn_id) : '0;
  assign own_wr    = WR_BITS'(req_r.txn_id) + 1'b1;
  assign is_writer = (rd_slot.writer == own_wr);
  assign others    = rd_slot.readers & ~own_bit;

  always_comb begin
    new_slot        = rd_slot;
    res             = '0;
    res.status      = ST_DONE;
    case (req_r.kind)
      KIND_READ, KIND_WRITE: begin
        if (!txn_ok) begin
          res.status = ST_BUSY;
        end else if (is_writer ||
                     (req_r.kind == KIND_READ && (rd_slot.readers & own_bit) != '0)) begin
          res.status = ST_HELD;
        end else if (rd_slot.writer != '0) begin
          res.status     = ST_BUSY;
          res.blocker_id = TXN_W'(rd_slot.writer - 1'b1);
        end else if (req_r.kind == KIND_READ) begin
          new_slot.readers = rd_slot.readers | own_bit;
        end else if (others != '0) begin
          res.status     = ST_BUSY;
          res.blocker_id = plk_lowest(others);
        end else begin
          new_slot.writer = own_wr;
        end
      end
      KIND_RELEASE: begin
        if (txn_ok) begin
          new_slot.readers = rd_slot.readers & ~own_bit;
          if (is_writer) begin
            new_slot.writer = '0;
          end
        end
      end
      KIND_SLOW_ENTER: begin
        if (rd_slot.slow == SLOW_MAX) begin
          res.count_error = 1'b1;
        end else begin
          new_slot.slow = rd_slot.slow + 1'b1;
        end
      end
      KIND_SLOW_LEAVE: begin
        if (rd_slot.slow == '0) begin
          res.count_error = 1'b1;
        end else begin
          new_slot.slow = rd_slot.slow - 1'b1;
        end
      end
      default: begin
        new_slot = rd_slot;
      end
    endcase
    res.writer_present = (new_slot.writer != '0);
    res.writer_id      = res.writer_present ? TXN_W'(new_slot.writer - 1'b1) : '0;
    res.reader_mask    = new_slot.readers;
    res.slow_readers   = new_slot.slow;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == PLK_EXEC))
    else $error("accepted beat did not enter the update cycle");

  a_result_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == PLK_EXEC))
    else $error("result strobe without an update cycle");

  a_busy_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == PLK_CLEAR) |-> (busy && !out_valid))
    else $error("block not busy during the clearing sweep");

  a_writer_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.writer_present) |-> (out_data.writer_id == '0))
    else $error("writer id reported without a writer");

endmodule

/* rtl/plk_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module plk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* test/page_lock_table_test.sv */
// Self-checking testbench for page_lock_table: directed lock, release and slow-reader beats,
// a saturation burst and random contention traffic, predicted by an in-bench lock table model.
// Depends on plk_pkg and page_lock_table; needs no files or arguments.
module page_lock_table_test;
  import plk_pkg::*;

  localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
  localparam int CYCLE_LIMIT   = 60000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BEATS  = 370;
  localparam int PRINT_CAP     = 40;

  class lock_table_board;
    plk_slot_t slot_store [SLOT_COUNT];
    plk_out_t  expected_replies [$];
    int mismatches, requests, replies, grants, held, conflicts, count_errors;

    function new();
      foreach (slot_store[i]) slot_store[i] = '0;
    endfunction

    // Applies one request to the local copy of the table and returns its reply.
    function plk_out_t predict_lock_step(plk_in_t req);
      plk_slot_t          s;
      plk_out_t           r;
      logic [RD_BITS-1:0] own;
      logic [RD_BITS-1:0] others;
      logic [WR_BITS-1:0] self_tag;
      bit                 found;
      s = slot_store[req.page_number[SLOT_AW-1:0]];
      r = '0;
      own = '0;
      own[req.txn_id] = 1'b1;
      self_tag = WR_BITS'(req.txn_id) + WR_BITS'(1);
      found = 1'b0;
      case (req.kind)
        KIND_READ, KIND_WRITE: begin
          if (int'(req.txn_id) >= TXN_COUNT) begin
            r.status = ST_BUSY;
          end else if (s.writer == self_tag ||
                       (req.kind == KIND_READ && (s.readers & own) != '0)) begin
            r.status = ST_HELD;
          end else if (s.writer != '0) begin
            r.status = ST_BUSY;
            r.blocker_id = TXN_W'(s.writer - 1);
          end else if (req.kind == KIND_READ) begin
            s.readers = s.readers | own;
          end else begin
            others = s.readers & ~own;
            if (others != '0) begin
              // The blocker is the lowest reader other than the requester.
              r.status = ST_BUSY;
              for (int i = 0; i < RD_BITS; i++) begin
                if (!found && others[i]) begin
                  r.blocker_id = TXN_W'(i);
                  found = 1'b1;
                end
              end
            end else begin
              s.writer = self_tag;
            end
          end
        end
        KIND_RELEASE: begin
          if (int'(req.txn_id) < TXN_COUNT) begin
            s.readers = s.readers & ~own;
            if (s.writer == self_tag) s.writer = '0;
          end
        end
        KIND_SLOW_ENTER: begin
          if (s.slow == SLOW_MAX) r.count_error = 1'b1;
          else s.slow = s.slow + 1'b1;
        end
        KIND_SLOW_LEAVE: begin
          if (s.slow == '0) r.count_error = 1'b1;
          else s.slow = s.slow - 1'b1;
        end
        default: begin
        end
      endcase
      slot_store[req.page_number[SLOT_AW-1:0]] = s;
      r.writer_present = (s.writer != '0);
      r.writer_id      = (s.writer != '0) ? TXN_W'(s.writer - 1) : '0;
      r.reader_mask    = s.readers;
      r.slow_readers   = s.slow;
      case (r.status)
        ST_HELD: held++;
        ST_BUSY: conflicts++;
        default: grants++;
      endcase
      if (r.count_error) count_errors++;
      return r;
    endfunction

    function void note_request(plk_in_t req);
      requests++;
      expected_replies.push_back(predict_lock_step(req));
    endfunction

    task report_mismatch(string what, longint unsigned want_v, longint unsigned got_v);
      if (mismatches < PRINT_CAP)
        $display("mismatch at reply %0d: %s expected 0x%0h got 0x%0h",
                 replies, what, want_v, got_v);
      mismatches++;
    endtask

    task check_reply(plk_out_t got);
      plk_out_t want;
      replies++;
      if (expected_replies.size() == 0) begin
        report_mismatch("reply with no request outstanding", 0, got);
        return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", want.status, got.status);
      if (got.blocker_id !== want.blocker_id)
        report_mismatch("blocker_id", want.blocker_id, got.blocker_id);
      if (got.writer_present !== want.writer_present)
        report_mismatch("writer_present", want.writer_present, got.writer_present);
      if (got.writer_id !== want.writer_id)
        report_mismatch("writer_id", want.writer_id, got.writer_id);
      if (got.reader_mask !== want.reader_mask)
        report_mismatch("reader_mask", want.reader_mask, got.reader_mask);
      if (got.slow_readers !== want.slow_readers)
        report_mismatch("slow_readers", want.slow_readers, got.slow_readers);
      if (got.count_error !== want.count_error)
        report_mismatch("count_error", want.count_error, got.count_error);
    endtask
  endclass

  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  logic     busy;
  plk_in_t  in_data = '0;
  logic     out_valid;
  plk_out_t out_data;

  lock_table_board    board = new();
  bit                 gaps_on = 1'b1;
  logic [SLOT_AW-1:0] hot_slots [8];
  int                 cycle_count = 0;

  page_lock_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && start === 1'b1 && busy === 1'b0) board.note_request(in_data);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) board.check_reply(out_data);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d replies outstanding",
               cycle_count, board.expected_replies.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic drive_request(input plk_in_t req);
    logic [63:0] noise;
    while (gaps_on && $urandom_range(99) < 37) begin
      noise   = {$urandom, $urandom};
      start   <= 1'b0;
      in_data <= noise[$bits(plk_in_t)-1:0];
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  task automatic send(input logic [2:0] kind, input logic [TXN_W-1:0] txn,
                      input logic [31:0] page);
    plk_in_t req;
    req.kind        = kind;
    req.txn_id      = txn;
    req.page_number = page;
    drive_request(req);
  endtask

  task automatic wait_until_drained();
    start <= 1'b0;
    while (board.expected_replies.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic logic [2:0] pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 30) return KIND_READ;
    if (r < 55) return KIND_WRITE;
    if (r < 78) return KIND_RELEASE;
    if (r < 87) return KIND_SLOW_ENTER;
    if (r < 96) return KIND_SLOW_LEAVE;
    return KIND_UNUSED_FIRST + 3'($urandom_range(2));
  endfunction

  // Most traffic lands on a few slots, with random upper page bits so aliases collide.
  function automatic logic [31:0] pick_page();
    logic [31:0] p;
    p = $urandom;
    if ($urandom_range(9) != 0) p[SLOT_AW-1:0] = hot_slots[$urandom_range(7)];
    return p;
  endfunction

  function automatic logic [TXN_W-1:0] pick_txn();
    if ($urandom_range(3) != 0) return TXN_W'($urandom_range(3));
    return TXN_W'($urandom_range(TXN_COUNT - 1));
  endfunction

  initial begin
    logic [31:0] sat_page;
    hot_slots[0] = '0;
    hot_slots[1] = '1;
    for (int i = 2; i < 8; i++) hot_slots[i] = SLOT_AW'($urandom);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Slot 0, reached also through an aliasing page number.
    send(KIND_READ,       4'd0,  32'h0000_0000);
    send(KIND_READ,       4'd0,  32'h0000_0000);
    send(KIND_WRITE,      4'd0,  32'h0000_0000);
    send(KIND_WRITE,      4'd0,  32'h0000_0000);
    send(KIND_READ,       4'd0,  32'h0000_0000);
    send(KIND_READ,       4'd5,  32'h0000_1000);
    send(KIND_WRITE,      4'd5,  32'h0000_0000);
    send(KIND_RELEASE,    4'd5,  32'h0000_0000);
    send(KIND_RELEASE,    4'd0,  32'h0000_0000);
    // Top slot: the write blocker must be the lowest reader other than the requester.
    send(KIND_READ,       4'd15, 32'hFFFF_FFFF);
    send(KIND_READ,       4'd3,  32'hFFFF_FFFF);
    send(KIND_READ,       4'd7,  32'hFFFF_FFFF);
    send(KIND_WRITE,      4'd3,  32'hFFFF_FFFF);
    send(KIND_WRITE,      4'd15, 32'hFFFF_FFFF);
    send(KIND_RELEASE,    4'd3,  32'hFFFF_FFFF);
    send(KIND_RELEASE,    4'd7,  32'hFFFF_FFFF);
    send(KIND_WRITE,      4'd15, 32'hFFFF_FFFF);
    send(KIND_READ,       4'd3,  32'hFFFF_FFFF);
    send(KIND_SLOW_LEAVE, 4'd9,  32'h8000_0123);
    send(KIND_SLOW_ENTER, 4'd9,  32'h8000_0123);
    send(KIND_SLOW_LEAVE, 4'd9,  32'h8000_0123);
    send(KIND_UNUSED_FIRST,        4'd15, 32'hFFFF_FFFF);
    send(KIND_UNUSED_FIRST + 3'd1, 4'd15, 32'hFFFF_FFFF);
    send(KIND_UNUSED_FIRST + 3'd2, 4'd15, 32'hFFFF_FFFF);
    send(KIND_RELEASE,    4'd15, 32'hFFFF_FFFF);
    wait_until_drained();

    // Drive one slot's slow reader count into its upper limit and back off it.
    sat_page = $urandom;
    repeat (257) send(KIND_SLOW_ENTER, TXN_W'($urandom), sat_page);
    repeat (3) send(KIND_SLOW_LEAVE, TXN_W'($urandom), sat_page);
    wait_until_drained();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      gaps_on = !(n >= 120 && n < 240);
      send(pick_kind(), pick_txn(), pick_page());
    end
    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d request beats: %0d done, %0d already held, %0d busy, %0d count limits",
             board.requests, board.grants, board.held, board.conflicts, board.count_errors);
    $display("checked %0d replies, %0d field mismatches", board.replies, board.mismatches);
    if (board.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
